/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/bde_pkg.sv */
// Package for the button debounce block: sizes, event codes, register map,
// types shared by lanes, merge stage and top level. No dependencies.
package bde_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int RING_SLOTS  = 8;
  localparam int MASK_W      = 5;
  localparam int CODE_W      = 4;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int PTR_W       = $clog2(RING_SLOTS);
  localparam int ADDR_W      = 4;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  localparam code_t EV_NONE        = CODE_W'(0);
  localparam code_t EV_MENU_SHORT  = CODE_W'(1);
  localparam code_t EV_MENU_LONG   = CODE_W'(2);
  localparam code_t EV_EXIT_SHORT  = CODE_W'(3);
  localparam code_t EV_EXIT_LONG   = CODE_W'(4);
  localparam code_t EV_CONF_SHORT  = CODE_W'(5);
  localparam code_t EV_CONF_LONG   = CODE_W'(6);
  localparam code_t EV_SCROLL_NEXT = CODE_W'(7);
  localparam code_t EV_SCROLL_PREV = CODE_W'(8);

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_MASK     = 2'd2;

  localparam logic [15:0]       DEBOUNCE_RST = 16'd30;
  localparam logic [15:0]       HOLD_RST     = 16'd500;
  localparam logic [MASK_W-1:0] MASK_RST     = MASK_W'(7);

  typedef struct packed {
    logic [15:0]       settle_ms;
    logic [15:0]       hold_ms;
    logic [MASK_W-1:0] hold_capable_mask;
  } cfg_t;

  typedef struct packed {
    code_t [NUM_BUTTONS-1:0] codes;
    logic                    any_down;
  } lane_bus_t;

  function automatic code_t short_code(idx_t i);
    code_t c;
    unique case (32'(i))
      0:       c = EV_MENU_SHORT;
      1:       c = EV_EXIT_SHORT;
      2:       c = EV_CONF_SHORT;
      3:       c = EV_SCROLL_NEXT;
      4:       c = EV_SCROLL_PREV;
      default: c = EV_NONE;
    endcase
    return c;
  endfunction

  function automatic code_t long_code(idx_t i);
    code_t c;
    unique case (32'(i))
      0:       c = EV_MENU_LONG;
      1:       c = EV_EXIT_LONG;
      2:       c = EV_CONF_LONG;
      default: c = EV_NONE;
    endcase
    return c;
  endfunction

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

/* rtl/core/bde_in_if.sv */
// Poll request channel: valid/ready plus raw levels and time.
// Depends on bde_pkg.
interface bde_in_if;
  import bde_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] button_levels;
  logic [31:0]            now_ms;

  modport source (output valid, button_levels, now_ms, input ready);
  modport sink (input valid, button_levels, now_ms, output ready);
  modport monitor (input valid, ready, button_levels, now_ms);
endinterface

/* rtl/core/bde_out_if.sv */
// Result channel: valid/ready plus popped event code and any-down flag.
// Depends on bde_pkg.
interface bde_out_if;
  import bde_pkg::*;

  logic        valid;
  logic        ready;
  code_t       event_code;
  logic        any_down;

  modport source (output valid, event_code, any_down, input ready);
  modport sink (input valid, event_code, any_down, output ready);
  modport monitor (input valid, ready, event_code, any_down);
endinterface

/* rtl/core/bde_lane.sv */
// One button lane: debounce, press timing and event detection.
// Depends on bde_pkg.
module bde_lane (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  bde_pkg::idx_t lane_idx_i,
  input  logic          raw_i,
  input  logic [31:0]   now_i,
  input  bde_pkg::cfg_t cfg_i,
  output bde_pkg::code_t code_o,
  output logic          stable_o
);
  import bde_pkg::*;

  logic        stable_q, stable_d;
  logic        last_raw_q;
  logic [31:0] lct_q, lct_d;
  logic [31:0] pst_q, pst_d;
  logic        ld_q, ld_d;
  logic        holdable;
  logic        acc_chg;
  logic [31:0] elapsed;
  logic [31:0] held;
  code_t       code;

  assign holdable = (32'(lane_idx_i) < MASK_W) &&
                    (((32'(cfg_i.hold_capable_mask) >> lane_idx_i) & 32'd1) != 32'd0);

  always_comb begin
    lct_d    = (raw_i != last_raw_q) ? now_i : lct_q;
    elapsed  = now_i - lct_d;
    acc_chg  = (elapsed > 32'(cfg_i.settle_ms)) && (stable_q != raw_i);
    stable_d = acc_chg ? raw_i : stable_q;
    pst_d    = pst_q;
    ld_d     = ld_q;
    code     = EV_NONE;
    if (acc_chg) begin
      if (!raw_i) begin
        pst_d = now_i;
        ld_d  = 1'b0;
        if (!holdable) begin
          code = short_code(lane_idx_i);
        end
      end else if (holdable && !ld_q) begin
        code = short_code(lane_idx_i);
      end
    end
    held = now_i - pst_d;
    // long event fires once per press, even when the button has no long code
    if (holdable && !stable_d && !ld_d && (held >= 32'(cfg_i.hold_ms))) begin
      ld_d = 1'b1;
      code = long_code(lane_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b1;
      last_raw_q <= 1'b1;
      lct_q      <= '0;
      pst_q      <= '0;
      ld_q       <= 1'b0;
    end else if (en_i) begin
      stable_q   <= stable_d;
      last_raw_q <= raw_i;
      lct_q      <= lct_d;
      pst_q      <= pst_d;
      ld_q       <= ld_d;
    end
  end

  assign code_o   = code;
  assign stable_o = stable_d;
endmodule

/* rtl/core/bde_merge.sv */
// Merge stage: queues lane events in index order into the event ring,
// pops at most one event per poll and holds the result register. Depends on bde_pkg.
module bde_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bde_pkg::lane_bus_t bus_i,
  output logic               ready_o,
  bde_out_if.source          out_o
);
  import bde_pkg::*;

  code_t ring_q [RING_SLOTS];
  code_t ring_d [RING_SLOTS];
  ptr_t  head_q, head_d;
  ptr_t  tail_q, tail_d;
  ptr_t  cnt_q, cnt_d;
  logic  out_valid_q;
  code_t out_code_q, pop_code;
  logic  out_down_q;
  logic  fire;

  assign ready_o = !out_valid_q || out_o.ready;
  assign fire    = valid_i && ready_o;

  always_comb begin
    ring_d   = ring_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    head_d   = head_q;
    pop_code = EV_NONE;
    // drop events once the ring holds RING_SLOTS-1 unread entries
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (bus_i.codes[i] != EV_NONE && cnt_d < PTR_W'(RING_SLOTS - 1)) begin
        ring_d[tail_d] = bus_i.codes[i];
        tail_d         = ptr_inc(tail_d);
        cnt_d          = cnt_d + ptr_t'(1);
      end
    end
    if (cnt_d != '0) begin
      pop_code = ring_d[head_q];
      head_d   = ptr_inc(head_q);
      cnt_d    = cnt_d - ptr_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ring_q <= ring_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_code_q <= pop_code;
      out_down_q <= bus_i.any_down;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_code = out_code_q;
  assign out_o.any_down   = out_down_q;
endmodule

/* rtl/core/button_debounce_press_events.sv */
// Top level of the button debounce block: config registers, button lanes,
// lane stage register and merge stage. Depends on bde_pkg, bde_in_if,
// bde_out_if, bde_lane and bde_merge.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        button_levels[4:0], now_ms[31:0]
//   out_o    out  valid/ready        event_code[3:0], any_down
//   apb      in   psel/penable/pwrite paddr[3:0], pwdata/prdata[31:0]
//
// One poll enters per cycle while in_i.ready is high; its result passes
// through the lane register, then the ring update and result register.
// Reset clears lanes, ring pointers and valid flags; ring slots are only
// read after a write, guarded by the occupancy count.
// A stalled result holds in the output register while the lane stage
// still takes one more request if it is empty.
module button_debounce_press_events (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bde_in_if.sink                     in_i,
  bde_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bde_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bde_pkg::*;

  cfg_t                   cfg_q;
  logic                   cfg_we;
  logic                   in_fire;
  logic                   merge_ready;
  logic                   valid_a_q;
  lane_bus_t              bus_q, bus_d;
  code_t [NUM_BUTTONS-1:0] lane_code;
  logic  [NUM_BUTTONS-1:0] lane_stable;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms         <= DEBOUNCE_RST;
      cfg_q.hold_ms           <= HOLD_RST;
      cfg_q.hold_capable_mask <= MASK_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE: cfg_q.settle_ms         <= pwdata[15:0];
        REG_HOLD:     cfg_q.hold_ms           <= pwdata[15:0];
        REG_MASK:     cfg_q.hold_capable_mask <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE: prdata = 32'(cfg_q.settle_ms);
      REG_HOLD:     prdata = 32'(cfg_q.hold_ms);
      REG_MASK:     prdata = 32'(cfg_q.hold_capable_mask);
      default:      prdata = '0;
    endcase
  end

  assign in_i.ready = !valid_a_q || merge_ready;
  assign in_fire    = in_i.valid && in_i.ready;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bde_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (in_fire),
      .lane_idx_i (IDX_W'(g)),
      .raw_i      (in_i.button_levels[g]),
      .now_i      (in_i.now_ms),
      .cfg_i      (cfg_q),
      .code_o     (lane_code[g]),
      .stable_o   (lane_stable[g])
    );
  end

  assign bus_d.codes    = lane_code;
  assign bus_d.any_down = ~&lane_stable;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_a_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bus_q <= bus_d;
    end
  end

  bde_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_a_q),
    .bus_i   (bus_q),
    .ready_o (merge_ready),
    .out_o   (out_o)
  );
endmodule

/* rtl/core/bde_checker.sv */
// Port-level checker for the button debounce block, bound to the top level.
// Depends on bde_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bde_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  bde_pkg::code_t event_code_i,
  input  logic           any_down_i,
  input  logic           pready_i
);
  import bde_pkg::*;

  logic              in_fire;
  logic              out_stall;
  logic              out_idle;
  logic [CODE_W:0]   out_word;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_idle  = !out_valid_i && !in_fire;
  assign out_word  = {event_code_i, any_down_i};

  `ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready_i)
  `ASSERT_ALWAYS(a_code_range, clk_i, rst_ni, !out_valid_i || event_code_i <= EV_SCROLL_PREV)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_word))
  `ASSERT_NEXT(a_no_phantom, clk_i, rst_ni, out_idle, !out_valid_i || $past(in_valid_i, 2))
endmodule

bind button_debounce_press_events bde_checker u_bde_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_code_i (out_o.event_code),
  .any_down_i   (out_o.any_down),
  .pready_i     (pready)
);
